>>> rtl/core/first_fit_segment_allocator_core_macros.svh
// Assertion macros for the allocator RTL.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFSA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ffsa_pkg.sv
`default_nettype none
package ffsa_pkg;

    localparam int POOL_SIZE_DEF = 256;
    localparam int MAX_SEG_DEF   = 32;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_FREE    = 2'd1;
    localparam logic [1:0] KIND_REALLOC = 2'd2;
    localparam logic [1:0] KIND_COMPACT = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_SPACE   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd4;

    typedef struct packed {
        logic [1:0] kind;
        logic [8:0] size;
        logic [7:0] handle;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] address;
        logic [7:0] old_address;
        logic [8:0] seg_length;
        logic       last;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FIND,
        S_ALLOC,
        S_REL,
        S_CMP
    } t_state;

    typedef enum logic [2:0] {
        RES_ERR,
        RES_ALLOC,
        RES_FREE,
        RES_RFAIL,
        RES_REALLOC,
        RES_MOVE,
        RES_TAIL
    } t_res_sel;

    typedef struct packed {
        logic       load;
        logic       ptr_clr;
        logic       ptr_inc;
        logic       save_idx;
        logic       release_cur;
        logic       release_idx;
        logic       take;
        logic       cmp_init;
        logic       cmp_step;
        logic       cmp_end;
        logic       emit;
        t_res_sel   res_sel;
        logic [2:0] res_status;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       size_zero;
        logic       at_end;
        logic       match;
        logic       fit;
        logic       exact;
        logic       full;
        logic       hole;
        logic       cur_busy;
    } t_stat;

endpackage
`default_nettype wire

>>> rtl/core/first_fit_segment_allocator_core.sv
`default_nettype none
// First-fit allocator over a byte pool kept as an address-ordered segment table.
// A request (kind, size, handle) transfers at a clock edge with start high and
// busy low. busy stays high until the request's final result has been issued.
// Each result appears on o_result for one cycle with o_strobe high; the
// receiver cannot stall, so results must be taken as they come. The final
// result of a request has last set; only compaction issues earlier results,
// one per relocated segment.
// Each request walks the segment table one entry per cycle: allocate walks
// for a first fit, free searches for the handle, reallocate does a handle
// search and then an allocation walk, and compact walks every table entry.
// The final result is registered from the last state of the request; busy
// drops in the cycle in which it strobes, and a new request may transfer then.
// A synchronous reset leaves one free segment spanning the whole pool; there
// is no clearing pass.
`include "first_fit_segment_allocator_core_macros.svh"
module first_fit_segment_allocator_core #(
    parameter int POOL_SIZE    = ffsa_pkg::POOL_SIZE_DEF,
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEG_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            start,
    output logic           busy,
    input  ffsa_pkg::t_req i_req,
    output ffsa_pkg::t_res o_result,
    output logic           o_strobe
);
    import ffsa_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ffsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ffsa_dp #(
        .POOL_SIZE    (POOL_SIZE),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

    `FFSA_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "request accepted but not busy")
    `FFSA_ASSERT_SAME(a_mid_result_busy, o_strobe && !o_result.last, busy, "non-final result while idle")
    `FFSA_ASSERT_SAME(a_error_is_last, o_strobe && o_result.status != ST_OK, o_result.last, "error result not final")

endmodule
`default_nettype wire

>>> rtl/core/ffsa_ctrl.sv
`default_nettype none
module ffsa_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_start,
    input  ffsa_pkg::t_stat i_stat,
    output ffsa_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    import ffsa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_sel    = RES_ERR;
        o_cmd.res_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.size_zero &&
                    (i_stat.kind == KIND_ALLOC || i_stat.kind == KIND_REALLOC)) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.res_status = ST_BAD_SIZE;
                    n_state          = S_IDLE;
                end else begin
                    case (i_stat.kind)
                        KIND_ALLOC:   n_state = S_ALLOC;
                        KIND_FREE:    n_state = S_FIND;
                        KIND_REALLOC: n_state = S_FIND;
                        default: begin
                            o_cmd.cmp_init = 1'b1;
                            n_state        = S_CMP;
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (i_stat.at_end) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.res_status = ST_NOT_FOUND;
                    n_state          = S_IDLE;
                end else if (i_stat.match) begin
                    if (i_stat.kind == KIND_FREE) begin
                        o_cmd.release_cur = 1'b1;
                        o_cmd.emit        = 1'b1;
                        o_cmd.res_sel     = RES_FREE;
                        n_state           = S_IDLE;
                    end else begin
                        o_cmd.save_idx = 1'b1;
                        o_cmd.ptr_clr  = 1'b1;
                        n_state        = S_ALLOC;
                    end
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_ALLOC: begin
                if (i_stat.at_end || (i_stat.fit && !i_stat.exact && i_stat.full)) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.res_sel    = (i_stat.kind == KIND_REALLOC) ? RES_RFAIL : RES_ERR;
                    o_cmd.res_status = i_stat.at_end ? ST_NO_SPACE : ST_TABLE_FULL;
                    n_state          = S_IDLE;
                end else if (i_stat.fit) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.kind == KIND_REALLOC) begin
                        n_state = S_REL;
                    end else begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.res_sel = RES_ALLOC;
                        n_state       = S_IDLE;
                    end
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_REL: begin
                o_cmd.release_idx = 1'b1;
                o_cmd.emit        = 1'b1;
                o_cmd.res_sel     = RES_REALLOC;
                n_state           = S_IDLE;
            end
            S_CMP: begin
                if (i_stat.at_end) begin
                    o_cmd.cmp_end = 1'b1;
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = RES_TAIL;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.cmp_step = 1'b1;
                    o_cmd.ptr_inc  = 1'b1;
                    if (i_stat.cur_busy && i_stat.hole) begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.res_sel = RES_MOVE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

>>> rtl/core/ffsa_dp.sv
`default_nettype none
module ffsa_dp #(
    parameter int POOL_SIZE    = ffsa_pkg::POOL_SIZE_DEF,
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEG_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  ffsa_pkg::t_req  i_req,
    input  ffsa_pkg::t_cmd  i_cmd,
    output ffsa_pkg::t_stat o_stat,
    output ffsa_pkg::t_res  o_result,
    output logic            o_strobe
);
    import ffsa_pkg::*;

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    logic [7:0]       r_start [MAX_SEGMENTS];
    logic [8:0]       r_len   [MAX_SEGMENTS];
    logic             r_busy  [MAX_SEGMENTS];
    logic [CNT_W-1:0] r_count;

    t_req             r_req;
    logic [CNT_W-1:0] r_ptr;
    logic [CNT_W-1:0] r_wr;
    logic [IDX_W-1:0] r_idx;
    logic [8:0]       r_oldlen;
    logic [7:0]       r_pos;
    logic [8:0]       r_hole_len;
    logic [8:0]       r_cur;
    logic             r_strobe;
    t_res             r_res;
    t_res             n_res;

    logic [IDX_W-1:0] ptr_idx;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       e_start;
    logic [8:0]       e_len;
    logic             e_busy;
    logic [8:0]       split_sum;
    logic             hole;

    assign ptr_idx   = r_ptr[IDX_W-1:0];
    assign wr_idx    = r_wr[IDX_W-1:0];
    assign e_start   = r_start[ptr_idx];
    assign e_len     = r_len[ptr_idx];
    assign e_busy    = r_busy[ptr_idx];
    assign split_sum = {1'b0, e_start} + r_req.size;
    assign hole      = (r_hole_len != '0);

    assign o_stat.kind      = r_req.kind;
    assign o_stat.size_zero = (r_req.size == '0);
    assign o_stat.at_end    = (r_ptr == r_count);
    assign o_stat.match     = e_busy && (e_start == r_req.handle);
    assign o_stat.fit       = !e_busy && (e_len >= r_req.size);
    assign o_stat.exact     = (e_len == r_req.size);
    assign o_stat.full      = (r_count == CNT_W'(MAX_SEGMENTS));
    assign o_stat.hole      = hole;
    assign o_stat.cur_busy  = e_busy;

    // Segment table. A split opens a hole after the pointer by moving the
    // upper entries up one place; compaction rewrites entries at r_wr.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_SEGMENTS; j++) begin
                r_busy[j] <= 1'b0;
            end
            r_start[0] <= '0;
            r_len[0]   <= 9'(POOL_SIZE);
            r_count    <= CNT_W'(1);
        end else begin
            if (i_cmd.take) begin
                if (o_stat.exact) begin
                    r_busy[ptr_idx] <= 1'b1;
                end else begin
                    for (int j = 1; j < MAX_SEGMENTS; j++) begin
                        if (j > int'(r_ptr) + 1 && j <= int'(r_count)) begin
                            r_start[j] <= r_start[j-1];
                            r_len[j]   <= r_len[j-1];
                            r_busy[j]  <= r_busy[j-1];
                        end else if (j == int'(r_ptr) + 1) begin
                            r_start[j] <= split_sum[7:0];
                            r_len[j]   <= e_len - r_req.size;
                            r_busy[j]  <= 1'b0;
                        end
                    end
                    r_len[ptr_idx]  <= r_req.size;
                    r_busy[ptr_idx] <= 1'b1;
                    r_count         <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.release_cur) begin
                r_busy[ptr_idx] <= 1'b0;
            end
            if (i_cmd.release_idx) begin
                r_busy[r_idx] <= 1'b0;
            end
            if (i_cmd.cmp_step && e_busy) begin
                r_start[wr_idx] <= r_cur[7:0];
                r_len[wr_idx]   <= e_len;
                r_busy[wr_idx]  <= 1'b1;
            end
            if (i_cmd.cmp_end) begin
                if (hole) begin
                    r_start[wr_idx] <= r_cur[7:0];
                    r_len[wr_idx]   <= r_hole_len;
                    r_busy[wr_idx]  <= 1'b0;
                    r_count         <= r_wr + CNT_W'(1);
                end else begin
                    r_count <= r_wr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.load || i_cmd.ptr_clr) begin
            r_ptr <= '0;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + CNT_W'(1);
        end
        if (i_cmd.save_idx) begin
            r_idx    <= ptr_idx;
            r_oldlen <= e_len;
        end else if (i_cmd.take && !o_stat.exact && ptr_idx < r_idx) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.take) begin
            r_pos <= e_start;
        end
        if (i_cmd.cmp_init) begin
            r_hole_len <= '0;
            r_cur      <= '0;
            r_wr       <= '0;
        end else if (i_cmd.cmp_step) begin
            if (e_busy) begin
                r_cur <= r_cur + e_len;
                r_wr  <= r_wr + CNT_W'(1);
            end else begin
                r_hole_len <= r_hole_len + e_len;
            end
        end
        if (i_cmd.emit) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_comb begin
        n_res        = '0;
        n_res.status = i_cmd.res_status;
        n_res.last   = (i_cmd.res_sel != RES_MOVE);
        case (i_cmd.res_sel)
            RES_ALLOC: begin
                n_res.address    = e_start;
                n_res.seg_length = r_req.size;
            end
            RES_FREE: begin
                n_res.address    = r_req.handle;
                n_res.seg_length = e_len;
            end
            RES_RFAIL: begin
                n_res.address     = r_req.handle;
                n_res.old_address = r_req.handle;
                n_res.seg_length  = r_oldlen;
            end
            RES_REALLOC: begin
                n_res.address     = r_pos;
                n_res.old_address = r_req.handle;
                n_res.seg_length  = r_req.size;
            end
            RES_MOVE: begin
                n_res.address     = r_cur[7:0];
                n_res.old_address = e_start;
                n_res.seg_length  = e_len;
            end
            RES_TAIL: begin
                if (hole) begin
                    n_res.address    = r_cur[7:0];
                    n_res.seg_length = r_hole_len;
                end
            end
            default: begin
                n_res.address = '0;
            end
        endcase
    end

    assign o_result = r_res;
    assign o_strobe = r_strobe;

endmodule
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import ffsa_pkg::*;

    localparam int POOL = 256;
    localparam int NSEG = 32;

    // Tracks the segment table and queues the results each request should produce.
    class alloc_scoreboard;
        logic [7:0] tbl_start [NSEG];
        logic [8:0] tbl_len [NSEG];
        bit         tbl_busy [NSEG];
        int         tbl_count;
        t_res       pending [$];
        int         mismatches;
        int         results_seen;
        int         moves_seen;

        function void clear();
            for (int i = 0; i < NSEG; i++) begin
                tbl_start[i] = '0;
                tbl_len[i] = '0;
                tbl_busy[i] = 1'b0;
            end
            tbl_len[0] = 9'(POOL);
            tbl_count = 1;
            pending.delete();
            mismatches = 0;
            results_seen = 0;
            moves_seen = 0;
        endfunction

        function void push(logic [2:0] st, logic [7:0] a, logic [7:0] o, logic [8:0] l,
                           logic lst);
            t_res r;
            r.status = st;
            r.address = a;
            r.old_address = o;
            r.seg_length = l;
            r.last = lst;
            pending.push_back(r);
        endfunction

        function int busy_index(logic [7:0] h);
            for (int i = 0; i < tbl_count; i++)
                if (tbl_busy[i] && tbl_start[i] == h)
                    return i;
            return -1;
        endfunction

        function logic [2:0] take_first_fit(logic [8:0] sz, output logic [7:0] where);
            where = '0;
            for (int i = 0; i < tbl_count; i++) begin
                if (tbl_busy[i] || tbl_len[i] < sz)
                    continue;
                if (tbl_len[i] == sz) begin
                    tbl_busy[i] = 1'b1;
                    where = tbl_start[i];
                    return ST_OK;
                end
                if (tbl_count >= NSEG)
                    return ST_TABLE_FULL;
                for (int j = tbl_count; j > i + 1; j--) begin
                    tbl_start[j] = tbl_start[j-1];
                    tbl_len[j] = tbl_len[j-1];
                    tbl_busy[j] = tbl_busy[j-1];
                end
                tbl_start[i+1] = tbl_start[i] + sz[7:0];
                tbl_len[i+1] = tbl_len[i] - sz;
                tbl_busy[i+1] = 1'b0;
                tbl_len[i] = sz;
                tbl_busy[i] = 1'b1;
                tbl_count++;
                where = tbl_start[i];
                return ST_OK;
            end
            return ST_NO_SPACE;
        endfunction

        function void note_request(t_req q);
            logic [2:0] st;
            logic [7:0] where;
            logic [8:0] oldlen;
            int idx;
            int i;
            logic [8:0] flen;
            logic [7:0] olds;
            case (q.kind)
                KIND_ALLOC: begin
                    if (q.size == '0) begin
                        push(ST_BAD_SIZE, '0, '0, '0, 1'b1);
                    end else begin
                        st = take_first_fit(q.size, where);
                        if (st != ST_OK) push(st, '0, '0, '0, 1'b1);
                        else push(ST_OK, where, '0, q.size, 1'b1);
                    end
                end
                KIND_FREE: begin
                    idx = busy_index(q.handle);
                    if (idx < 0) begin
                        push(ST_NOT_FOUND, '0, '0, '0, 1'b1);
                    end else begin
                        tbl_busy[idx] = 1'b0;
                        push(ST_OK, q.handle, '0, tbl_len[idx], 1'b1);
                    end
                end
                KIND_REALLOC: begin
                    idx = busy_index(q.handle);
                    if (q.size == '0) begin
                        push(ST_BAD_SIZE, '0, '0, '0, 1'b1);
                    end else if (idx < 0) begin
                        push(ST_NOT_FOUND, '0, '0, '0, 1'b1);
                    end else begin
                        oldlen = tbl_len[idx];
                        st = take_first_fit(q.size, where);
                        if (st != ST_OK) begin
                            push(st, q.handle, q.handle, oldlen, 1'b1);
                        end else begin
                            idx = busy_index(q.handle);
                            if (idx >= 0) tbl_busy[idx] = 1'b0;
                            push(ST_OK, where, q.handle, q.size, 1'b1);
                        end
                    end
                end
                default: begin
                    i = 0;
                    while (i + 1 < tbl_count) begin
                        if (!tbl_busy[i] && !tbl_busy[i+1]) begin
                            tbl_len[i] += tbl_len[i+1];
                            for (int j = i + 1; j + 1 < tbl_count; j++) begin
                                tbl_start[j] = tbl_start[j+1];
                                tbl_len[j] = tbl_len[j+1];
                                tbl_busy[j] = tbl_busy[j+1];
                            end
                            tbl_count--;
                            continue;
                        end
                        if (!tbl_busy[i] && tbl_busy[i+1]) begin
                            flen = tbl_len[i];
                            olds = tbl_start[i+1];
                            tbl_busy[i] = 1'b1;
                            tbl_len[i] = tbl_len[i+1];
                            tbl_busy[i+1] = 1'b0;
                            tbl_len[i+1] = flen;
                            tbl_start[i+1] = tbl_start[i] + tbl_len[i][7:0];
                            push(ST_OK, tbl_start[i], olds, tbl_len[i], 1'b0);
                            moves_seen++;
                        end
                        i++;
                    end
                    if (!tbl_busy[tbl_count-1])
                        push(ST_OK, tbl_start[tbl_count-1], '0, tbl_len[tbl_count-1], 1'b1);
                    else
                        push(ST_OK, '0, '0, '0, 1'b1);
                end
            endcase
        endfunction

        function void check_result(t_res got);
            t_res exp;
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", exp, got);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_req i_req = '0;
    logic busy;
    t_res o_result;
    logic o_strobe;
    alloc_scoreboard board;
    int kind_count [4];
    int burst_left;

    always #10 i_clk = ~i_clk;

    first_fit_segment_allocator_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_result(o_result),
        .o_strobe(o_strobe)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            board.check_result(o_result);
        end
    end

    // One transfer; bursts of back-to-back requests alternate with random gaps.
    // Within a burst start stays high, and the next request is set up at the
    // edge that accepted the previous one.
    task automatic send_request(logic [1:0] k, logic [8:0] sz, logic [7:0] h);
        t_req q;
        int gap;
        q.kind = k;
        q.size = sz;
        q.handle = h;
        if (burst_left == 0) begin
            gap = int'($urandom_range(0, 12));
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = int'($urandom_range(1, 8));
        end
        burst_left--;
        start <= 1'b1;
        i_req <= q;
        do @(posedge i_clk); while (busy);
        board.note_request(q);
        kind_count[k]++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Picks a handle that is mostly a live busy segment start.
    function automatic logic [7:0] pick_handle();
        int idx;
        if ($urandom_range(0, 9) < 8) begin
            idx = int'($urandom_range(0, board.tbl_count - 1));
            for (int n = 0; n < board.tbl_count; n++) begin
                if (board.tbl_busy[(idx + n) % board.tbl_count])
                    return board.tbl_start[(idx + n) % board.tbl_count];
            end
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [8:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 9'd0;
            1: return 9'($urandom_range(0, 511));
            2: return 9'($urandom_range(64, 256));
            default: return 9'($urandom_range(1, 16));
        endcase
    endfunction

    initial begin
        int r;
        board = new();
        board.clear();
        burst_left = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        send_request(KIND_ALLOC, 9'd0, 8'd0);
        send_request(KIND_ALLOC, 9'd511, 8'd0);
        send_request(KIND_ALLOC, 9'd257, 8'd0);
        send_request(KIND_ALLOC, 9'd1, 8'd0);
        send_request(KIND_ALLOC, 9'd255, 8'd0);
        send_request(KIND_ALLOC, 9'd1, 8'd0);
        send_request(KIND_FREE, 9'd0, 8'd0);
        send_request(KIND_FREE, 9'd0, 8'd0);
        send_request(KIND_FREE, 9'd0, 8'd255);
        send_request(KIND_REALLOC, 9'd0, 8'd1);
        send_request(KIND_REALLOC, 9'd4, 8'd77);
        send_request(KIND_REALLOC, 9'd300, 8'd1);
        send_request(KIND_REALLOC, 9'd1, 8'd1);
        send_request(KIND_COMPACT, 9'h1ff, 8'hff);
        send_request(KIND_FREE, 9'd0, 8'd0);
        send_request(KIND_COMPACT, 9'd0, 8'd0);
        send_request(KIND_ALLOC, 9'd256, 8'd0);
        send_request(KIND_FREE, 9'd0, 8'd0);
        wait_drained();
        // Fill the table with small grants to reach the full-table refusal.
        for (int n = 0; n < 33; n++)
            send_request(KIND_ALLOC, 9'd2, 8'($urandom));
        send_request(KIND_ALLOC, 9'd3, 8'd0);
        send_request(KIND_REALLOC, 9'd3, 8'd0);
        wait_drained();

        // Random part: mostly live handles, some noise.
        for (int n = 0; n < 215; n++) begin
            r = $urandom_range(0, 99);
            if (r < 40) send_request(KIND_ALLOC, pick_size(), 8'($urandom));
            else if (r < 70) send_request(KIND_FREE, 9'($urandom), pick_handle());
            else if (r < 90) send_request(KIND_REALLOC, pick_size(), pick_handle());
            else send_request(KIND_COMPACT, 9'($urandom), 8'($urandom));
            if (n == 100) wait_drained();
        end

        wait_drained();
        repeat (80) @(posedge i_clk);
        $display("covered %0d alloc, %0d free, %0d realloc, %0d compact requests",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
        $display("checked %0d results including %0d relocations",
                 board.results_seen, board.moves_seen);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ffsa_pkg.sv
rtl/core/ffsa_ctrl.sv
rtl/core/ffsa_dp.sv
rtl/core/first_fit_segment_allocator_core.sv
test/testbench.sv
